// ===== rtl/gcd_pkg.sv =====
package gcd_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'd1;

  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

  // raster position of a cell
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pos_t;

  // line store entry: [1] two rows up, [0] one row up
  typedef logic [1:0] ls_word_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    ls_word_t          data;
  } ls_wr_t;

  typedef struct packed {
    logic busy;     // a cell sits in the window stage
    logic advance;  // that cell moves on this cycle
  } win_stat_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] max);
    logic [SIZE_W-1:0] res;
    if (v < MIN_SIZE) res = MIN_SIZE;
    else if (v > max) res = max;
    else res = v;
    return res;
  endfunction

  // bit = 3*row + col, row 0 on top, col 0 oldest
  function automatic logic is_corner(input logic [8:0] w);
    logic res;
    res = 1'b0;
    if (!w[4]) begin
      if (w[0] && !w[1] && !w[3]) res = 1'b1;
      if (w[2] && !w[1] && !w[5]) res = 1'b1;
      if (w[6] && !w[3] && !w[7]) res = 1'b1;
      if (w[8] && !w[5] && !w[7]) res = 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== rtl/gcd_cell_if.sv =====
interface gcd_cell_if;
  logic valid;
  logic ready;
  logic is_blocked;

  modport source (output valid, output is_blocked, input ready);
  modport sink (input valid, input is_blocked, output ready);
endinterface

// ===== rtl/gcd_corner_if.sv =====
interface gcd_corner_if;
  logic                        valid;
  logic                        ready;
  logic [gcd_pkg::COORD_W-1:0] corner_x;
  logic [gcd_pkg::COORD_W-1:0] corner_y;

  modport source (output valid, output corner_x, output corner_y, input ready);
  modport sink (input valid, input corner_x, input corner_y, output ready);
endinterface

// ===== rtl/gcd_raster_cnt.sv =====
module gcd_raster_cnt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [gcd_pkg::SIZE_W-1:0] width_i,
  input  logic [gcd_pkg::SIZE_W-1:0] height_i,
  output gcd_pkg::pos_t              pos_o
);

  gcd_pkg::pos_t              pos_q, pos_d;
  logic [gcd_pkg::SIZE_W-1:0] col_next, row_next;

  assign col_next = {1'b0, pos_q.col} + gcd_pkg::SIZE_W'(1);
  assign row_next = {1'b0, pos_q.row} + gcd_pkg::SIZE_W'(1);

  always_comb begin
    pos_d = pos_q;
    if (step_i) begin
      if (col_next >= width_i) begin
        pos_d.col = '0;
        pos_d.row = (row_next >= height_i) ? '0 : row_next[gcd_pkg::COORD_W-1:0];
      end else begin
        pos_d.col = col_next[gcd_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== rtl/gcd_line_store.sv =====
module gcd_line_store (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [gcd_pkg::ADDR_W-1:0] rd_addr_i,
  output gcd_pkg::ls_word_t          rd_data_o,
  input  gcd_pkg::ls_wr_t            wr_i
);

  gcd_pkg::ls_word_t mem [gcd_pkg::MAX_WIDTH];
  gcd_pkg::ls_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/gcd_window.sv =====
module gcd_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  logic                        bit_i,
  input  gcd_pkg::pos_t               pos_i,
  input  gcd_pkg::ls_word_t           rd_data_i,
  input  logic                        out_ready_i,
  output gcd_pkg::win_stat_t          stat_o,
  output gcd_pkg::ls_wr_t             wr_o,
  output logic                        out_valid_o,
  output logic [gcd_pkg::COORD_W-1:0] corner_x_o,
  output logic [gcd_pkg::COORD_W-1:0] corner_y_o
);

  // cell stage: holds the accepted cell while the line store read is registered
  logic                        s1_valid_q;
  logic                        s1_bit_q;
  gcd_pkg::pos_t               s1_pos_q;
  logic [8:0]                  window_q, window_d;
  logic                        out_valid_q;
  logic [gcd_pkg::COORD_W-1:0] corner_x_q, corner_y_q;
  logic                        advance, hit;

  assign advance = s1_valid_q && (!out_valid_q || out_ready_i);

  assign window_d = ((window_q >> 1) & 9'h0DB)
                  | (9'(rd_data_i[1]) << 2)
                  | (9'(rd_data_i[0]) << 5)
                  | (9'(s1_bit_q) << 8);

  assign hit = (s1_pos_q.col >= gcd_pkg::COORD_W'(2)) && (s1_pos_q.row >= gcd_pkg::COORD_W'(2))
            && gcd_pkg::is_corner(window_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        window_q    <= window_d;
        out_valid_q <= hit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_bit_q <= bit_i;
      s1_pos_q <= pos_i;
    end
    if (advance && hit) begin
      corner_x_q <= s1_pos_q.col - gcd_pkg::COORD_W'(1);
      corner_y_q <= s1_pos_q.row - gcd_pkg::COORD_W'(1);
    end
  end

  // the row above moves to two rows up, the new cell becomes the row above
  assign wr_o.en   = advance;
  assign wr_o.addr = s1_pos_q.col[gcd_pkg::ADDR_W-1:0];
  assign wr_o.data = {rd_data_i[0], s1_bit_q};

  assign stat_o.busy    = s1_valid_q;
  assign stat_o.advance = advance;

  assign out_valid_o = out_valid_q;
  assign corner_x_o  = corner_x_q;
  assign corner_y_o  = corner_y_q;

endmodule

// ===== rtl/grid_corner_detector_core.sv =====
// Streaming corner detector for grid maps. Obstacle bits (1 = blocked) enter one word per
// clock when not stalled, in row-major raster order; every free interior cell with a blocked
// diagonal whose two flanking orthogonal neighbours are free comes out as one (corner_x,
// corner_y) word, in raster order, once the cell one row below and one column right has been
// accepted. Throughput is one cell per clock while nothing stalls. Accepting a cell registers
// it with the read of the 1024 x 2-bit line store; the window shift and corner test then load
// the result register as the window stage advances. A result held by a low corner_o.ready
// stops the window stage, and the input stalls while a cell waits there behind it.
// The map size registers are clamped to 3..1024, reset to 1024 and must be written only while
// the block is idle; after the last cell of a map the position wraps to (0,0). The line store is
// not cleared: the first two rows of the first map after reset must be fully streamed before
// results are meaningful, which normal raster order guarantees.
module grid_corner_detector_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gcd_cell_if.sink                      cell_i,
  gcd_corner_if.source                  corner_o,
  input  logic                          cfg_we_i,
  input  logic [gcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gcd_pkg::SIZE_W-1:0]    cfg_data_i
);

  logic [gcd_pkg::SIZE_W-1:0] map_width_q, map_height_q;
  logic [gcd_pkg::SIZE_W-1:0] width_eff, height_eff;
  logic                       accept;
  gcd_pkg::pos_t              pos;
  gcd_pkg::ls_word_t          rd_data;
  gcd_pkg::ls_wr_t            ls_wr;
  gcd_pkg::win_stat_t         win_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= gcd_pkg::SIZE_W'(gcd_pkg::MAX_WIDTH);
      map_height_q <= gcd_pkg::SIZE_W'(gcd_pkg::MAX_HEIGHT);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gcd_pkg::CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        gcd_pkg::CFG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = gcd_pkg::clamp_size(map_width_q, gcd_pkg::SIZE_W'(gcd_pkg::MAX_WIDTH));
  assign height_eff = gcd_pkg::clamp_size(map_height_q, gcd_pkg::SIZE_W'(gcd_pkg::MAX_HEIGHT));

  assign cell_i.ready = !win_stat.busy || win_stat.advance;
  assign accept       = cell_i.valid && cell_i.ready;

  gcd_raster_cnt u_cnt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .width_i  (width_eff),
    .height_i (height_eff),
    .pos_o    (pos)
  );

  gcd_line_store u_ls (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (pos.col[gcd_pkg::ADDR_W-1:0]),
    .rd_data_o (rd_data),
    .wr_i      (ls_wr)
  );

  gcd_window u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (accept),
    .bit_i       (cell_i.is_blocked),
    .pos_i       (pos),
    .rd_data_i   (rd_data),
    .out_ready_i (corner_o.ready),
    .stat_o      (win_stat),
    .wr_o        (ls_wr),
    .out_valid_o (corner_o.valid),
    .corner_x_o  (corner_o.corner_x),
    .corner_y_o  (corner_o.corner_y)
  );

  // a read never hits the column being written back
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && ls_wr.en && (pos.col[gcd_pkg::ADDR_W-1:0] == ls_wr.addr)))
    else $error("line store read and write hit the same column");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cell_i.ready |-> (win_stat.busy && corner_o.valid && !corner_o.ready))
    else $error("input stalled without a held result");

  // corners are interior cells
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corner_o.valid |-> (corner_o.corner_x != '0) && (corner_o.corner_y != '0))
    else $error("corner reported on the border");

  // a new result comes only from a cell in the window stage
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(corner_o.valid) |-> $past(win_stat.advance))
    else $error("result appeared without a cell moving on");

endmodule

// ===== dv/tb_grid_corner_detector_core.sv =====
module tb_grid_corner_detector_core;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [gcd_pkg::COORD_W-1:0] x;
    logic [gcd_pkg::COORD_W-1:0] y;
  } corner_pos_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [gcd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [gcd_pkg::SIZE_W-1:0]    cfg_data;

  gcd_cell_if   cell_if();
  gcd_corner_if corner_if();

  grid_corner_detector_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (cell_if),
    .corner_o   (corner_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor state: size registers, two rows of history, 3x3 window, raster position
  logic [gcd_pkg::SIZE_W-1:0] map_w_reg;
  logic [gcd_pkg::SIZE_W-1:0] map_h_reg;
  bit                         row_above [gcd_pkg::MAX_WIDTH];
  bit                         row_above2[gcd_pkg::MAX_WIDTH];
  logic [8:0]                 win;
  int unsigned                pos_col;
  int unsigned                pos_row;

  corner_pos_t expected_corners[$];
  int          error_count;
  int          idle_pct;
  int          stall_pct;
  int          quiet_cycles = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned fold_size(input logic [gcd_pkg::SIZE_W-1:0] v,
                                            input int unsigned top);
    int unsigned res;
    res = v;
    if (res < 3) res = 3;
    else if (res > top) res = top;
    return res;
  endfunction

  function automatic void predict_cell(input bit blocked);
    int unsigned w_eff;
    int unsigned h_eff;
    bit          a1;
    bit          a2;
    bit          hit;
    corner_pos_t pos;
    w_eff = fold_size(map_w_reg, gcd_pkg::MAX_WIDTH);
    h_eff = fold_size(map_h_reg, gcd_pkg::MAX_HEIGHT);
    a2 = row_above2[pos_col];
    a1 = row_above[pos_col];
    row_above2[pos_col] = a1;
    row_above[pos_col]  = blocked;
    // new column enters on the right, oldest column drops off the left
    win = {blocked, win[8:7], a1, win[5:4], a2, win[2:1]};
    hit = !win[4] && ((win[0] && !win[1] && !win[3]) || (win[2] && !win[1] && !win[5]) ||
                      (win[6] && !win[3] && !win[7]) || (win[8] && !win[5] && !win[7]));
    if (pos_col >= 2 && pos_row >= 2 && hit) begin
      pos.x = gcd_pkg::COORD_W'(pos_col - 1);
      pos.y = gcd_pkg::COORD_W'(pos_row - 1);
      expected_corners = {expected_corners, pos};
    end
    if (pos_col + 1 >= w_eff) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= h_eff) ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
  endfunction

  always @(posedge clk_i) begin
    corner_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    corner_pos_t exp_pos;
    if (rst_ni && corner_if.valid && corner_if.ready) begin
      if (expected_corners.size() == 0) begin
        $display("%0t: unexpected corner word x=%0d y=%0d", $time,
                 corner_if.corner_x, corner_if.corner_y);
        error_count++;
      end else begin
        exp_pos = expected_corners.pop_front();
        if (corner_if.corner_x !== exp_pos.x) begin
          $display("%0t: corner_x expected %0d actual %0d", $time, exp_pos.x,
                   corner_if.corner_x);
          error_count++;
        end
        if (corner_if.corner_y !== exp_pos.y) begin
          $display("%0t: corner_y expected %0d actual %0d", $time, exp_pos.y,
                   corner_if.corner_y);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cell_if.valid && cell_if.ready) || (corner_if.valid && corner_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d corners outstanding", $time,
               expected_corners.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_cell(input bit blocked);
    while ($urandom_range(99) < idle_pct) begin
      cell_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_if.valid      <= 1'b1;
    cell_if.is_blocked <= blocked;
    @(posedge clk_i);
    while (!cell_if.ready) @(posedge clk_i);
    predict_cell(blocked);
  endtask

  task automatic wait_idle();
    cell_if.valid <= 1'b0;
    while (expected_corners.size() != 0) @(posedge clk_i);
    // cells that make no corner may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcd_pkg::SIZE_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      gcd_pkg::CFG_MAP_WIDTH:  map_w_reg = val;
      gcd_pkg::CFG_MAP_HEIGHT: map_h_reg = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_map(input logic [gcd_pkg::SIZE_W-1:0] w,
                         input logic [gcd_pkg::SIZE_W-1:0] h);
    wait_idle();
    write_reg(gcd_pkg::CFG_MAP_WIDTH, w);
    write_reg(gcd_pkg::CFG_MAP_HEIGHT, h);
  endtask

  task automatic send_random_cells(input int n, input int density);
    repeat (n) send_cell($urandom_range(99) < density);
  endtask

  task automatic finish_map();
    while (pos_col != 0 || pos_row != 0) send_cell($urandom_range(1));
  endtask

  // this first map fills every line store column that later maps reach
  task automatic test_first_map();
    set_map(gcd_pkg::SIZE_W'(64), gcd_pkg::SIZE_W'(3));
    send_random_cells(64 * 3, 30);
  endtask

  // one 3x3 map per window pattern, bit 3*row+col
  task automatic test_directed_corners();
    logic [8:0] patterns[6];
    patterns = '{9'h001, 9'h004, 9'h040, 9'h100, 9'h003, 9'h111};
    set_map(gcd_pkg::SIZE_W'(3), gcd_pkg::SIZE_W'(3));
    foreach (patterns[p]) begin
      for (int i = 0; i < 9; i++) send_cell(patterns[p][i]);
    end
  endtask

  task automatic test_size_clamp();
    set_map(gcd_pkg::SIZE_W'(0), gcd_pkg::SIZE_W'(2047));
    send_random_cells(3 * 6, 35);
    // full width, kept inside the columns the first map wrote
    set_map(gcd_pkg::SIZE_W'(2047), gcd_pkg::SIZE_W'(1));
    send_random_cells(40, 25);
    // two maps back to back: position wraps, history is kept
    set_map(gcd_pkg::SIZE_W'(2), gcd_pkg::SIZE_W'(0));
    send_random_cells(18, 40);
  endtask

  task automatic test_map_wrap();
    set_map(gcd_pkg::SIZE_W'(7), gcd_pkg::SIZE_W'(4));
    send_random_cells(7 * 4 * 3, 30);
  endtask

  task automatic test_midmap_write();
    set_map(gcd_pkg::SIZE_W'(12), gcd_pkg::SIZE_W'(6));
    send_random_cells(12 * 6 + 40, 30);
    wait_idle();
    write_reg(gcd_pkg::CFG_MAP_WIDTH, gcd_pkg::SIZE_W'(5));
    send_random_cells(13, 30);
    wait_idle();
    write_reg(gcd_pkg::CFG_MAP_HEIGHT, gcd_pkg::SIZE_W'(2));
    send_random_cells(20, 30);
    set_map(gcd_pkg::SIZE_W'(9), gcd_pkg::SIZE_W'(5));
    finish_map();
  endtask

  task automatic test_random_maps(input int idle, input int stall, input int n_cells);
    int sent;
    int mw;
    int mh;
    int density;
    int n;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_cells) begin
      mw = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
      mh = $urandom_range(3, 8);
      density = ($urandom_range(9) == 0) ? $urandom_range(0, 100) : $urandom_range(10, 50);
      set_map(gcd_pkg::SIZE_W'(mw), gcd_pkg::SIZE_W'(mh));
      // now and then a map is cut short and the next size lands mid-map
      n = ($urandom_range(7) == 0) ? $urandom_range(1, mw * mh - 1) : mw * mh;
      send_random_cells(n, density);
      sent += n;
    end
  endtask

  initial begin
    cell_if.valid      <= 1'b0;
    cell_if.is_blocked <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= gcd_pkg::CFG_MAP_WIDTH;
    cfg_data           <= '0;
    rst_ni             <= 1'b0;
    map_w_reg   = gcd_pkg::SIZE_W'(gcd_pkg::MAX_WIDTH);
    map_h_reg   = gcd_pkg::SIZE_W'(gcd_pkg::MAX_HEIGHT);
    win         = '0;
    pos_col     = 0;
    pos_row     = 0;
    error_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_map();
    test_directed_corners();
    test_size_clamp();
    test_map_wrap();
    test_midmap_write();
    test_random_maps(0, 0, 280);
    test_random_maps(54, 0, 280);
    test_random_maps(0, 54, 280);
    test_random_maps(6, 6, 280);

    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gcd_pkg.sv
rtl/gcd_cell_if.sv
rtl/gcd_corner_if.sv
rtl/gcd_raster_cnt.sv
rtl/gcd_line_store.sv
rtl/gcd_window.sv
rtl/grid_corner_detector_core.sv
dv/tb_grid_corner_detector_core.sv
